### rtl/png_scanline_unfilter_macros.svh
// assertion macros shared by the unfilter checker
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PNGU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("png unfilter check failed");

// next-cycle implication, checked on every rising edge outside reset
`define PNGU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("png unfilter check failed");

`endif

### rtl/pngu_pkg.sv
// shared types and constants of the png scanline unfilter
`default_nettype none

package pngu_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BPP_W      = 4;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES      = 1'd1;

  // highest legal filter code in the stream
  localparam logic [BYTE_W-1:0] FILTER_CODE_MAX = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filter_e;

  typedef struct packed {
    logic [BYTE_W-1:0] filtered_byte;
    logic              image_start;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              line_end;
    logic              bad_filter;
  } out_t;

  // operands of one byte reconstruction
  typedef struct packed {
    filter_e           filt;
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
  } pred_in_t;

endpackage

`default_nettype wire

### rtl/pngu_predict.sv
// predictor and modulo-256 add for one reconstructed byte
`default_nettype none

module pngu_predict (
  input  pngu_pkg::pred_in_t          op_i,
  output logic [pngu_pkg::BYTE_W-1:0] recon_o
);
  import pngu_pkg::*;

  logic [BYTE_W:0]   sum_ab;
  logic [BYTE_W:0]   sum_cc;
  logic [BYTE_W-1:0] pa;
  logic [BYTE_W-1:0] pb;
  logic [BYTE_W:0]   pc;
  logic [BYTE_W-1:0] paeth;
  logic [BYTE_W-1:0] pred;

  always_comb begin
    sum_ab = {1'b0, op_i.a} + {1'b0, op_i.b};
    sum_cc = {1'b0, op_i.c} + {1'b0, op_i.c};
    pa = (op_i.b > op_i.c) ? op_i.b - op_i.c : op_i.c - op_i.b;
    pb = (op_i.a > op_i.c) ? op_i.a - op_i.c : op_i.c - op_i.a;
    pc = (sum_ab > sum_cc) ? sum_ab - sum_cc : sum_cc - sum_ab;
    // ties favour a, then b
    if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
      paeth = op_i.a;
    end else if ({1'b0, pb} <= pc) begin
      paeth = op_i.b;
    end else begin
      paeth = op_i.c;
    end
  end

  always_comb begin
    case (op_i.filt)
      FILT_SUB:   pred = op_i.a;
      FILT_UP:    pred = op_i.b;
      FILT_AVG:   pred = sum_ab[BYTE_W:1];
      FILT_PAETH: pred = paeth;
      default:    pred = '0;
    endcase
  end

  assign recon_o = op_i.x + pred;

endmodule

`default_nettype wire

### rtl/png_scanline_unfilter.sv
// top level of the png scanline unfilter
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | in        | in_valid_i / in_ready_o    | in_data_i  (filter or data)
//  out     | out       | out_valid_o / out_ready_i  | out_data_o (one per data byte)
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one byte per cycle sustained unless a result is held; the prior row memory is read at the edge
// that takes a transaction, the byte is rebuilt in the reconstruct stage in the next cycle and is
// registered in the output register, which drives out_valid_o
// filter bytes occupy one slot in the reconstruct stage and give no result
// reset: no clearing pass, prior row reads are masked to zero on the first row
// in_ready_o drops once a data byte waits in the reconstruct stage behind a held result
`default_nettype none

module png_scanline_unfilter #(
  parameter int unsigned MAX_LINE_BYTES  = 4096,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pngu_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pngu_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pngu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pngu_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pngu_pkg::*;

  localparam int unsigned AW      = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int unsigned LANE_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  // longest row the length register can express within the memory depth
  localparam int unsigned LEN_CAP = (MAX_LINE_BYTES > LEN_MAX) ? LEN_MAX : MAX_LINE_BYTES;

  // configuration registers
  logic [BPP_W-1:0] bpp_q;
  logic [LEN_W-1:0] len_q;

  // read stage state
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]  pos_cur;
  filter_e           row_filt_q;
  logic              first_row_q;
  logic [LANE_W-1:0] lane_cnt_q [MAX_PIXEL_BYTES];

  // reconstruct stage
  logic              s1_valid_q;
  logic              s1_is_filt_q;
  logic [BYTE_W-1:0] s1_x_q;
  logic [LANE_W-1:0] s1_lane_q;
  logic [AW-1:0]     s1_addr_q;
  filter_e           s1_filt_q;
  logic              s1_first_q;
  logic              s1_last_q;

  // pixel lane histories
  logic [BYTE_W-1:0] left_q  [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] upleft_q[MAX_PIXEL_BYTES];

  // prior row memory
  logic [BYTE_W-1:0] prior_mem [MAX_LINE_BYTES];
  logic [BYTE_W-1:0] prior_rd_q;

  // output register
  logic out_valid_q;
  out_t out_data_q;

  logic              in_acc;
  logic              s1_adv;
  logic              is_filt;
  logic [LEN_W-1:0]  len_eff;
  logic [BPP_W-1:0]  bpp_eff;
  logic [LEN_W-1:0]  data_idx;
  logic [AW-1:0]     rd_addr;
  logic [LANE_W-1:0] lane_sel;
  logic              is_last;
  filter_e           code_filt;
  pred_in_t          pred_op;
  logic [BYTE_W-1:0] recon;
  logic [BYTE_W-1:0] b_val;

  // handshakes: the reconstruct stage drains unless a result is held up
  assign s1_adv      = s1_valid_q & (s1_is_filt_q | ~out_valid_q | out_ready_i);
  assign in_ready_o  = ~s1_valid_q | s1_adv;
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // clamp out-of-range register values
  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(len_q) > LEN_CAP) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = len_q;
    end
    if (bpp_q == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (32'(bpp_q) > MAX_PIXEL_BYTES) begin
      bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_q;
    end
  end

  // read stage decode: image start forces a filter byte
  always_comb begin
    pos_cur  = in_data_i.image_start ? '0 : pos_q;
    is_filt  = (pos_cur == '0);
    data_idx = pos_cur - LEN_W'(1);
    if (32'(data_idx) >= MAX_LINE_BYTES) begin
      rd_addr = AW'(MAX_LINE_BYTES - 1);
    end else begin
      rd_addr = AW'(data_idx);
    end
    // one wrap counter per pixel width keeps the lane exact even if the width changes
    lane_sel  = lane_cnt_q[LANE_W'(bpp_eff - BPP_W'(1))];
    is_last   = (pos_cur >= len_eff);
    code_filt = (in_data_i.filtered_byte <= FILTER_CODE_MAX) ?
                filter_e'(in_data_i.filtered_byte[2:0]) : FILT_BAD;
    if (is_filt) begin
      pos_d = LEN_W'(1);
    end else if (is_last) begin
      pos_d = '0;
    end else begin
      pos_d = pos_cur + LEN_W'(1);
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= BPP_W'(1);
      len_q <= LEN_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BYTES_PER_PIXEL: bpp_q <= cfg_data_i[BPP_W-1:0];
        REG_LINE_BYTES:      len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // row tracking, updated per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      row_filt_q  <= FILT_NONE;
      first_row_q <= 1'b1;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        lane_cnt_q[k] <= '0;
      end
    end else if (in_acc) begin
      pos_q <= pos_d;
      if (is_filt) begin
        row_filt_q <= code_filt;
        if (in_data_i.image_start) begin
          first_row_q <= 1'b1;
        end
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          lane_cnt_q[k] <= '0;
        end
      end else begin
        if (is_last) begin
          first_row_q <= 1'b0;
        end
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          lane_cnt_q[k] <= (lane_cnt_q[k] == LANE_W'(k)) ? '0 : lane_cnt_q[k] + LANE_W'(1);
        end
      end
    end
  end

  // reconstruct stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // reconstruct stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_is_filt_q <= is_filt;
      s1_x_q       <= in_data_i.filtered_byte;
      s1_lane_q    <= lane_sel;
      s1_addr_q    <= rd_addr;
      s1_filt_q    <= row_filt_q;
      s1_first_q   <= first_row_q;
      s1_last_q    <= is_last;
    end
  end

  // prior row: read on data accept, written back when the result leaves the stage;
  // consecutive data bytes never share an entry, and a new row is always led by
  // its filter byte, so a read never races the pending write
  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_is_filt_q) begin
      prior_mem[s1_addr_q] <= recon;
    end
    if (in_acc && !is_filt) begin
      prior_rd_q <= prior_mem[rd_addr];
    end
  end

  assign b_val = s1_first_q ? '0 : prior_rd_q;

  always_comb begin
    pred_op.filt = s1_filt_q;
    pred_op.x    = s1_x_q;
    pred_op.a    = left_q[s1_lane_q];
    pred_op.b    = b_val;
    pred_op.c    = upleft_q[s1_lane_q];
  end

  pngu_predict u_predict (
    .op_i    (pred_op),
    .recon_o (recon)
  );

  // lane histories: cleared by each filter byte, updated by each data byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_q[k]   <= '0;
        upleft_q[k] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_is_filt_q) begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          left_q[k]   <= '0;
          upleft_q[k] <= '0;
        end
      end else begin
        left_q[s1_lane_q]   <= recon;
        upleft_q[s1_lane_q] <= b_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && !s1_is_filt_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_is_filt_q) begin
      out_data_q.pixel_byte <= recon;
      out_data_q.line_end   <= s1_last_q;
      out_data_q.bad_filter <= (s1_filt_q == FILT_BAD);
    end
  end

endmodule

`default_nettype wire

### rtl/pngu_checker.sv
// port-level checks of the png scanline unfilter, bound to the top level
`default_nettype none
`include "png_scanline_unfilter_macros.svh"

module pngu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input pngu_pkg::out_t out_data_o,
  input logic           cfg_valid_i,
  input logic           cfg_ready_o
);

  // a held result stays put until taken
  `PNGU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // with the output free or draining, the input side never stalls
  `PNGU_ASSERT_NOW(a_in_flow, !out_valid_o || out_ready_i, in_ready_o)

  // configuration transactions are never stalled
  `PNGU_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

  // a stalled input transaction with the output not taken means a result is still waiting in the next cycle
  `PNGU_ASSERT_NEXT(a_stall_cause, in_valid_i && !in_ready_o && !out_ready_i, out_valid_o)

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (.*);

`default_nettype wire
